### hw/rtl/frustum_box_cull_macros.svh
`ifndef FRUSTUM_BOX_CULL_MACROS_SVH
`define FRUSTUM_BOX_CULL_MACROS_SVH

// same-cycle implication, checked outside reset
`define FBC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frustum_box_cull check failed");

// next-cycle implication, checked outside reset
`define FBC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frustum_box_cull check failed");

`endif

### hw/rtl/fbc_pkg.sv
package fbc_pkg;

   // field and value widths
   localparam int FIELD_BITS = 32;
   localparam int VALUE_BITS = 32;
   localparam int VAL_W      = (VALUE_BITS >= FIELD_BITS) ? FIELD_BITS : VALUE_BITS;
   localparam int IDX_BITS   = 4;
   localparam int FRAC_BITS  = 16;

   // plane arithmetic widths
   localparam int NORM_BITS = FIELD_BITS + 1;
   localparam int PROD_BITS = NORM_BITS + FIELD_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;

   // matrix shape
   localparam int MAT_DIM  = 4;
   localparam int NORM_DIM = 3;
   localparam logic [1:0] ROW_BASE = 2'd3;

   // chain and result queue sizing
   localparam int NUM_CELLS  = 6;
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TEST = 1'b1
   } op_type;

   // one item as it moves along the cell chain
   typedef struct packed {
      logic                              valid;
      op_type                            op;
      logic [IDX_BITS-1:0]               elem_index;
      logic [FIELD_BITS-1:0]             value;
      logic [NORM_DIM-1:0][FIELD_BITS-1:0] box_min;
      logic [NORM_DIM-1:0][FIELD_BITS-1:0] box_max;
      logic                              visible;
   } item_type;

   // which plane a cell owns: row3 plus or minus row
   typedef struct packed {
      logic [1:0] row;
      logic       neg;
   } plane_id_type;

   // sign-extend the low VAL_W bits of a field
   function automatic logic signed [FIELD_BITS-1:0] take_value(
      input logic [FIELD_BITS-1:0] raw);
      logic [FIELD_BITS-1:0] shifted;
      shifted = raw << (FIELD_BITS - VAL_W);
      return $signed(shifted) >>> (FIELD_BITS - VAL_W);
   endfunction

endpackage

### hw/rtl/fbc_stream_if.sv
// request channel: load or test item
interface fbc_req_if;
   import fbc_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [IDX_BITS-1:0]          elem_index;
   logic signed [FIELD_BITS-1:0] matrix_value;
   logic signed [FIELD_BITS-1:0] box_min_x;
   logic signed [FIELD_BITS-1:0] box_min_y;
   logic signed [FIELD_BITS-1:0] box_min_z;
   logic signed [FIELD_BITS-1:0] box_max_x;
   logic signed [FIELD_BITS-1:0] box_max_y;
   logic signed [FIELD_BITS-1:0] box_max_z;

   modport source (
      output valid, op, elem_index, matrix_value,
             box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      input  ready
   );
   modport sink (
      input  valid, op, elem_index, matrix_value,
             box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      output ready
   );
endinterface

// response channel: cull verdict
interface fbc_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink (input valid, inside_res, output ready);
endinterface

### hw/rtl/fbc_plane_cell.sv
module fbc_plane_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  fbc_pkg::plane_id_type plane_id,
   input  fbc_pkg::item_type    item_i,
   output fbc_pkg::item_type    item_o
);
   import fbc_pkg::*;

   // local copy of the matrix entries this plane needs
   logic [FIELD_BITS-1:0] base_ff [MAT_DIM];
   logic [FIELD_BITS-1:0] base_in [MAT_DIM];
   logic [FIELD_BITS-1:0] row_ff  [MAT_DIM];
   logic [FIELD_BITS-1:0] row_in  [MAT_DIM];
   // plane normal in columns 0..2, offset in column 3
   logic [NORM_BITS-1:0]  coef_ff [MAT_DIM];
   logic [NORM_BITS-1:0]  coef_in [MAT_DIM];

   logic       load_hit;
   logic [1:0] load_col;
   logic [1:0] load_row;

   logic [FIELD_BITS-1:0]       corner  [NORM_DIM];
   logic signed [PROD_BITS-1:0] prod_in [NORM_DIM];
   logic signed [PROD_BITS-1:0] prod_ff [NORM_DIM];
   logic [NORM_BITS-1:0]        offset_ff;
   logic                        active_in;
   logic                        active_ff;
   item_type                    mid_ff;

   logic [SUM_BITS-1:0] sum;
   logic                reject;
   item_type            out_in;
   item_type            out_ff;

   assign load_hit = item_i.valid && (item_i.op == OP_LOAD);
   assign load_col = item_i.elem_index[3:2];
   assign load_row = item_i.elem_index[1:0];

   // load path: update entries and recompute plane coefficients
   always_comb begin
      for (int c = 0; c < MAT_DIM; c++) begin
         base_in[c] = base_ff[c];
         row_in[c]  = row_ff[c];
         if (load_hit && (load_col == 2'(c))) begin
            if (load_row == ROW_BASE) begin
               base_in[c] = item_i.value;
            end
            if (load_row == plane_id.row) begin
               row_in[c] = item_i.value;
            end
         end
         if (plane_id.neg) begin
            coef_in[c] = {base_in[c][FIELD_BITS-1], base_in[c]}
                       - {row_in[c][FIELD_BITS-1], row_in[c]};
         end else begin
            coef_in[c] = {base_in[c][FIELD_BITS-1], base_in[c]}
                       + {row_in[c][FIELD_BITS-1], row_in[c]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MAT_DIM; c++) begin
            base_ff[c] <= '0;
            row_ff[c]  <= '0;
            coef_ff[c] <= '0;
         end
      end else if (load_hit) begin
         base_ff <= base_in;
         row_ff  <= row_in;
         coef_ff <= coef_in;
      end
   end

   // stage one: pick the far corner and multiply
   always_comb begin
      for (int k = 0; k < NORM_DIM; k++) begin
         corner[k]  = coef_ff[k][NORM_BITS-1] ? item_i.box_min[k] : item_i.box_max[k];
         prod_in[k] = $signed(coef_ff[k]) * $signed(corner[k]);
      end
      active_in = (coef_ff[0] != '0) || (coef_ff[1] != '0) || (coef_ff[2] != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid <= 1'b0;
      end else begin
         mid_ff <= item_i;
      end
      prod_ff   <= prod_in;
      offset_ff <= coef_ff[MAT_DIM-1];
      active_ff <= active_in;
   end

   // stage two: sum of products plus scaled offset, test the sign
   always_comb begin
      sum = {{(SUM_BITS-PROD_BITS){prod_ff[0][PROD_BITS-1]}}, prod_ff[0]}
          + {{(SUM_BITS-PROD_BITS){prod_ff[1][PROD_BITS-1]}}, prod_ff[1]}
          + {{(SUM_BITS-PROD_BITS){prod_ff[2][PROD_BITS-1]}}, prod_ff[2]}
          + {{(SUM_BITS-NORM_BITS-FRAC_BITS){offset_ff[NORM_BITS-1]}},
             offset_ff, {FRAC_BITS{1'b0}}};
      reject = active_ff && sum[SUM_BITS-1];
      out_in = mid_ff;
      out_in.visible = mid_ff.visible && !reject;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff <= out_in;
      end
   end

   assign item_o = out_ff;

endmodule

### hw/rtl/fbc_result_fifo.sv
`include "frustum_box_cull_macros.svh"

module fbc_result_fifo (
   input  logic clock,
   input  logic reset,
   input  logic wr_en,
   input  logic wr_data,
   input  logic rd_en,
   output logic rd_valid,
   output logic rd_data
);
   import fbc_pkg::*;

   logic               mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff;
   logic [FIFO_AW-1:0] wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff;
   logic [FIFO_AW-1:0] rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];

   // no write into a full queue
   `FBC_ASSERT_IMP(a_fifo_no_overflow, clock, reset, wr_en, (count_ff < CNT_W'(FIFO_DEPTH)) || rd_en)

endmodule

### hw/rtl/frustum_box_cull.sv
// path: an accepted test item passes the input register and both stages of each cell into the result queue
// throughput: one item per clock while ready is high, set by six plane cells of two stages each
// (three 33x32 multipliers per cell); loads flow down the same chain, no result
// ready drops only while 16 test results are in flight or waiting in the queue
// reset: synchronous, clears every cell's matrix copy to zero and empties the chain
`include "frustum_box_cull_macros.svh"

module frustum_box_cull (
   input  logic      clock,
   input  logic      reset,
   fbc_req_if.sink   req_chan,
   fbc_rsp_if.source rsp_chan
);
   import fbc_pkg::*;

   logic             req_acc;
   logic             test_acc;
   logic             rsp_acc;
   logic [CNT_W-1:0] outstanding_ff;
   logic [CNT_W-1:0] outstanding_in;

   item_type in_ff;
   item_type in_in;
   item_type cell_in  [NUM_CELLS];
   item_type cell_out [NUM_CELLS];
   item_type last_item;
   logic     result_wr;

   // admission: one slot per test result not yet delivered
   assign req_chan.ready = (outstanding_ff < CNT_W'(FIFO_DEPTH));
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign test_acc = req_acc && (op_type'(req_chan.op) == OP_TEST);
   assign rsp_acc  = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      case ({test_acc, rsp_acc})
         2'b10:   outstanding_in = outstanding_ff + 1'b1;
         2'b01:   outstanding_in = outstanding_ff - 1'b1;
         default: outstanding_in = outstanding_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // input register, values trimmed to the working width
   always_comb begin
      in_in.valid      = req_acc;
      in_in.op         = op_type'(req_chan.op);
      in_in.elem_index = req_chan.elem_index;
      in_in.value      = take_value(req_chan.matrix_value);
      in_in.box_min[0] = take_value(req_chan.box_min_x);
      in_in.box_min[1] = take_value(req_chan.box_min_y);
      in_in.box_min[2] = take_value(req_chan.box_min_z);
      in_in.box_max[0] = take_value(req_chan.box_max_x);
      in_in.box_max[1] = take_value(req_chan.box_max_y);
      in_in.box_max[2] = take_value(req_chan.box_max_z);
      in_in.visible    = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid <= 1'b0;
      end else begin
         in_ff <= in_in;
      end
   end

   // chain of plane cells: +row0, -row0, +row1, -row1, +row2, -row2
   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign cell_in[g] = in_ff;
      end else begin : g_link
         assign cell_in[g] = cell_out[g-1];
      end

      fbc_plane_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .plane_id (plane_id_type'{row: 2'(g / 2), neg: 1'(g % 2)}),
         .item_i   (cell_in[g]),
         .item_o   (cell_out[g])
      );
   end

   // finished tests go to the result queue
   assign last_item = cell_out[NUM_CELLS-1];
   assign result_wr = last_item.valid && (last_item.op == OP_TEST);

   fbc_result_fifo u_result_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (result_wr),
      .wr_data  (last_item.visible),
      .rd_en    (rsp_acc),
      .rd_valid (rsp_chan.valid),
      .rd_data  (rsp_chan.inside_res)
   );

   // credit bookkeeping
   `FBC_ASSERT_IMP(a_credit_bound, clock, reset, 1'b1, outstanding_ff <= CNT_W'(FIFO_DEPTH))
   `FBC_ASSERT_IMP(a_rsp_has_credit, clock, reset, rsp_chan.valid, outstanding_ff != '0)
   `FBC_ASSERT_IMP(a_done_has_credit, clock, reset, result_wr, outstanding_ff != '0)
   `FBC_ASSERT_NEXT(a_credit_step, clock, reset, test_acc && !rsp_acc, outstanding_ff == $past(outstanding_ff) + 1'b1)

endmodule

### tb/sv/tb_frustum_box_cull.sv
`timescale 1ns / 1ps

module tb_frustum_box_cull;
   import fbc_pkg::*;

   localparam int QUIET_LIMIT  = 5000;
   localparam int LONG_STALL   = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 510;

   localparam logic [FIELD_BITS-1:0] ONE      = 'h1_0000;
   localparam logic [FIELD_BITS-1:0] HALF     = 'h8000;
   localparam logic [FIELD_BITS-1:0] NEG_ONE  = -ONE;
   localparam logic [FIELD_BITS-1:0] NEG_HALF = -HALF;
   localparam logic [FIELD_BITS-1:0] MOST_NEG = {1'b1, {(FIELD_BITS-1){1'b0}}};
   localparam logic [FIELD_BITS-1:0] MOST_POS = {1'b0, {(FIELD_BITS-1){1'b1}}};

   // one request item as the sender holds it
   typedef struct {
      op_type                op;
      logic [IDX_BITS-1:0]   elem_index;
      logic [FIELD_BITS-1:0] matrix_value;
      logic [FIELD_BITS-1:0] box_min_x;
      logic [FIELD_BITS-1:0] box_min_y;
      logic [FIELD_BITS-1:0] box_min_z;
      logic [FIELD_BITS-1:0] box_max_x;
      logic [FIELD_BITS-1:0] box_max_y;
      logic [FIELD_BITS-1:0] box_max_z;
   } cull_req_type;

   logic clock = 1'b0;
   logic reset;

   fbc_req_if req_if ();
   fbc_rsp_if rsp_if ();

   frustum_box_cull dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // predictor state: matrix copy and verdicts still owed by the block
   logic signed [FIELD_BITS-1:0] view_proj [MAT_DIM*MAT_DIM];
   logic                         expected_verdicts [$];
   cull_req_type                 pending_reqs [$];

   int   items_sent;
   int   items_taken;
   int   error_count;
   int   quiet_cycles;
   int   send_idle_pct;
   int   recv_idle_pct;
   logic stall_armed;
   logic stall_done;
   int   stall_count;
   logic req_fire;
   logic rsp_fire;

   cull_req_type next_req;
   cull_req_type seen_req;
   logic         want_inside;

   always #5 clock = ~clock;

   // sign-extend the low VAL_W bits of a field
   function automatic logic signed [FIELD_BITS-1:0] widen_value(
      input logic [FIELD_BITS-1:0] raw);
      logic [FIELD_BITS-1:0] v;
      v = raw;
      for (int b = VAL_W; b < FIELD_BITS; b++) v[b] = raw[VAL_W-1];
      return $signed(v);
   endfunction

   // exact six-plane test against the current matrix copy
   function automatic logic box_survives(input cull_req_type it);
      logic signed [FIELD_BITS-1:0] lo [NORM_DIM];
      logic signed [FIELD_BITS-1:0] hi [NORM_DIM];
      logic signed [NORM_BITS-1:0]  nrm [NORM_DIM];
      logic signed [NORM_BITS-1:0]  base;
      logic signed [NORM_BITS-1:0]  row;
      logic signed [NORM_BITS-1:0]  ofs;
      logic signed [95:0]           acc;
      logic signed [95:0]           wide_n;
      logic signed [95:0]           wide_p;
      logic                         survives;
      survives = 1'b1;
      lo[0] = widen_value(it.box_min_x);
      lo[1] = widen_value(it.box_min_y);
      lo[2] = widen_value(it.box_min_z);
      hi[0] = widen_value(it.box_max_x);
      hi[1] = widen_value(it.box_max_y);
      hi[2] = widen_value(it.box_max_z);
      for (int r = 0; r < NORM_DIM; r++) begin
         for (int s = 0; s < 2; s++) begin
            // plane is row3 plus or minus row r
            for (int k = 0; k < NORM_DIM; k++) begin
               base   = view_proj[k*MAT_DIM + 3];
               row    = view_proj[k*MAT_DIM + r];
               nrm[k] = (s != 0) ? base - row : base + row;
            end
            base = view_proj[3*MAT_DIM + 3];
            row  = view_proj[3*MAT_DIM + r];
            ofs  = (s != 0) ? base - row : base + row;
            // all-zero normal never rejects
            if (nrm[0] != 0 || nrm[1] != 0 || nrm[2] != 0) begin
               acc = ofs;
               acc = acc <<< FRAC_BITS;
               // corner furthest along the normal, zero picks the maximum
               for (int k = 0; k < NORM_DIM; k++) begin
                  wide_n = nrm[k];
                  wide_p = (nrm[k] >= 0) ? hi[k] : lo[k];
                  acc    = acc + wide_n * wide_p;
               end
               if (acc < 0) survives = 1'b0;
            end
         end
      end
      return survives;
   endfunction

   function automatic logic [FIELD_BITS-1:0] rand_value();
      logic [FIELD_BITS-1:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = int'($urandom_range(0, 524288)) - 262144;
         4, 5:       v = $urandom();
         6:          v = '0;
         7:          v = $urandom_range(1) ? ONE : NEG_ONE;
         8:          v = $urandom_range(1) ? MOST_NEG : MOST_POS;
         default:    v = int'($urandom_range(0, 511)) - 256;
      endcase
      return v;
   endfunction

   task automatic queue_item(input cull_req_type it);
      pending_reqs.push_back(it);
      items_sent++;
   endtask

   task automatic queue_load(input int idx, input logic [FIELD_BITS-1:0] val);
      cull_req_type it;
      it.op           = OP_LOAD;
      it.elem_index   = IDX_BITS'(idx);
      it.matrix_value = val;
      it.box_min_x    = $urandom();
      it.box_min_y    = $urandom();
      it.box_min_z    = $urandom();
      it.box_max_x    = $urandom();
      it.box_max_y    = $urandom();
      it.box_max_z    = $urandom();
      queue_item(it);
   endtask

   task automatic queue_test(input logic [FIELD_BITS-1:0] min_x, min_y, min_z,
                             input logic [FIELD_BITS-1:0] max_x, max_y, max_z);
      cull_req_type it;
      it.op           = OP_TEST;
      it.elem_index   = IDX_BITS'($urandom_range(15));
      it.matrix_value = $urandom();
      it.box_min_x    = min_x;
      it.box_min_y    = min_y;
      it.box_min_z    = min_z;
      it.box_max_x    = max_x;
      it.box_max_y    = max_y;
      it.box_max_z    = max_z;
      queue_item(it);
   endtask

   // box test with a mix of small, swapped, extreme and raw boxes
   task automatic queue_random_test();
      logic [FIELD_BITS-1:0] c  [NORM_DIM];
      logic [FIELD_BITS-1:0] h  [NORM_DIM];
      logic [FIELD_BITS-1:0] lo [NORM_DIM];
      logic [FIELD_BITS-1:0] hi [NORM_DIM];
      int                    mode;
      mode = $urandom_range(9);
      for (int k = 0; k < NORM_DIM; k++) begin
         c[k] = int'($urandom_range(0, 1048576)) - 524288;
         h[k] = $urandom_range(0, 262144);
         case (mode)
            6: begin
               lo[k] = $urandom();
               hi[k] = $urandom();
            end
            7: begin
               lo[k] = c[k] + h[k];
               hi[k] = c[k] - h[k];
            end
            8: begin
               lo[k] = $urandom_range(1) ? MOST_NEG : MOST_POS;
               hi[k] = $urandom_range(1) ? MOST_NEG : MOST_POS;
            end
            9: begin
               lo[k] = $urandom_range(1) ? MOST_NEG : c[k] - h[k];
               hi[k] = $urandom_range(1) ? MOST_POS : c[k] + h[k];
            end
            default: begin
               lo[k] = c[k] - h[k];
               hi[k] = c[k] + h[k];
            end
         endcase
      end
      queue_test(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endtask

   // matrix loads followed by box tests, with some raw items mixed in
   task automatic queue_random_phase(input int count);
      int           done;
      int           n;
      int           row;
      cull_req_type junk;
      done = 0;
      while (done < count) begin
         if ($urandom_range(9) < 7) begin
            if ($urandom_range(1) != 0) begin
               for (int e = 0; e < MAT_DIM*MAT_DIM; e++) queue_load(e, rand_value());
               done += MAT_DIM*MAT_DIM;
            end else begin
               n = $urandom_range(1, 6);
               repeat (n) queue_load($urandom_range(15), rand_value());
               done += n;
            end
            // clear row 3 and one other row so two planes lose their normal
            if ($urandom_range(3) == 0) begin
               row = $urandom_range(2);
               for (int c = 0; c < NORM_DIM; c++) begin
                  queue_load(c*MAT_DIM + 3, '0);
                  queue_load(c*MAT_DIM + row, '0);
               end
               done += 2*NORM_DIM;
            end
            n = $urandom_range(1, 12);
            repeat (n) queue_random_test();
            done += n;
         end else begin
            junk.op           = op_type'($urandom_range(1));
            junk.elem_index   = IDX_BITS'($urandom_range(15));
            junk.matrix_value = $urandom();
            junk.box_min_x    = $urandom();
            junk.box_min_y    = $urandom();
            junk.box_min_z    = $urandom();
            junk.box_max_x    = $urandom();
            junk.box_max_y    = $urandom();
            junk.box_max_z    = $urandom();
            queue_item(junk);
            done++;
         end
      end
   endtask

   // hold the sender back until every item is taken and every verdict is in
   task automatic wait_for_drain();
      do @(negedge clock);
      while (items_taken != items_sent || expected_verdicts.size() != 0);
      @(posedge clock);
   endtask

   // sender: offers the next pending item, holds it until taken
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = pending_reqs.pop_front();
            req_if.op           <= next_req.op;
            req_if.elem_index   <= next_req.elem_index;
            req_if.matrix_value <= next_req.matrix_value;
            req_if.box_min_x    <= next_req.box_min_x;
            req_if.box_min_y    <= next_req.box_min_y;
            req_if.box_min_z    <= next_req.box_min_z;
            req_if.box_max_x    <= next_req.box_max_x;
            req_if.box_max_y    <= next_req.box_max_y;
            req_if.box_max_z    <= next_req.box_max_z;
            req_if.valid        <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver: random back-pressure, plus one long hold-off when armed
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_armed && !stall_done) begin
         rsp_if.ready <= 1'b0;
         if (stall_count == LONG_STALL) stall_done = 1'b1;
         else stall_count++;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: update the predictor on each taken item, check each verdict
   always @(posedge clock) begin
      req_fire = !reset && req_if.valid && req_if.ready;
      rsp_fire = !reset && rsp_if.valid && rsp_if.ready;
      if (reset) begin
         for (int e = 0; e < MAT_DIM*MAT_DIM; e++) view_proj[e] = '0;
         expected_verdicts.delete();
      end
      if (req_fire) begin
         items_taken++;
         if (op_type'(req_if.op) == OP_LOAD) begin
            view_proj[req_if.elem_index] = widen_value(req_if.matrix_value);
         end else begin
            seen_req.op           = OP_TEST;
            seen_req.elem_index   = req_if.elem_index;
            seen_req.matrix_value = req_if.matrix_value;
            seen_req.box_min_x    = req_if.box_min_x;
            seen_req.box_min_y    = req_if.box_min_y;
            seen_req.box_min_z    = req_if.box_min_z;
            seen_req.box_max_x    = req_if.box_max_x;
            seen_req.box_max_y    = req_if.box_max_y;
            seen_req.box_max_z    = req_if.box_max_z;
            expected_verdicts.push_back(box_survives(seen_req));
         end
      end
      if (rsp_fire) begin
         if (expected_verdicts.size() == 0) begin
            $error("inside_res: expected none, actual %0b", rsp_if.inside_res);
            error_count++;
         end else begin
            want_inside = expected_verdicts.pop_front();
            if (rsp_if.inside_res !== want_inside) begin
               $error("inside_res: expected %0b, actual %0b", want_inside, rsp_if.inside_res);
               error_count++;
            end
         end
      end
      if (reset || req_fire || rsp_fire) quiet_cycles = 0;
      else quiet_cycles++;
   end

   // watchdog on a channel pair that stopped moving
   always @(negedge clock) begin
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.op           = OP_LOAD;
      req_if.elem_index   = '0;
      req_if.matrix_value = '0;
      req_if.box_min_x    = '0;
      req_if.box_min_y    = '0;
      req_if.box_min_z    = '0;
      req_if.box_max_x    = '0;
      req_if.box_max_y    = '0;
      req_if.box_max_z    = '0;
      rsp_if.ready        = 1'b0;
      items_sent          = 0;
      items_taken         = 0;
      error_count         = 0;
      quiet_cycles        = 0;
      send_idle_pct       = 0;
      recv_idle_pct       = 0;
      stall_armed         = 1'b0;
      stall_done          = 1'b0;
      stall_count         = 0;
      req_fire            = 1'b0;
      rsp_fire            = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty matrix: every normal is zero, nothing is culled
      queue_test(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS);
      queue_test(MOST_POS, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, MOST_NEG);
      // zero normals with a negative offset still never reject
      queue_load(15, NEG_ONE);
      queue_test(NEG_HALF, NEG_HALF, NEG_HALF, HALF, HALF, HALF);
      // identity matrix: unit cube frustum
      queue_load(0, ONE);
      queue_load(5, ONE);
      queue_load(10, ONE);
      queue_load(15, ONE);
      queue_test(NEG_HALF, NEG_HALF, NEG_HALF, HALF, HALF, HALF);
      queue_test(2*ONE, NEG_HALF, NEG_HALF, 3*ONE, HALF, HALF);
      queue_test(NEG_HALF, -3*ONE, NEG_HALF, HALF, -2*ONE, HALF);
      queue_test(NEG_HALF, NEG_HALF, HALF, HALF, HALF, 5*ONE);
      queue_test(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS);
      queue_test(MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS);
      queue_test(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
      // swapped box is used as given
      queue_test(HALF, HALF, HALF, NEG_HALF, NEG_HALF, NEG_HALF);
      queue_test(5*ONE, NEG_HALF, NEG_HALF, -5*ONE, HALF, HALF);
      // extreme matrix entries
      queue_load(3, MOST_NEG);
      queue_load(12, MOST_POS);
      queue_test(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS);
      queue_load(7, MOST_POS);
      queue_test('0, '0, '0, '0, '0, '0);
      // zero normal component picks the box maximum
      queue_load(0, '0);
      queue_test(NEG_ONE, MOST_NEG, '0, ONE, MOST_POS, ONE);
      wait_for_drain();

      // sender idles lightly, receiver heavily
      send_idle_pct = 35;
      recv_idle_pct = 80;
      queue_random_phase(PHASE_ITEMS);
      wait_for_drain();

      // sender idles heavily, receiver lightly
      send_idle_pct = 80;
      recv_idle_pct = 35;
      queue_random_phase(PHASE_ITEMS);
      wait_for_drain();

      // no idling, one long receiver hold-off while the sender keeps offering
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_armed   = 1'b1;
      queue_random_phase(PHASE_ITEMS);
      wait_for_drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
